>>> rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam logic [2:0] EXT16_LEFT = 3'd1;
   localparam logic [2:0] EXT64_LEFT = 3'd7;
   localparam logic [1:0] KEY_LAST_IDX = 2'd3;

   typedef enum logic [4:0] {
      PH_HDR0    = 5'b00001,
      PH_HDR1    = 5'b00010,
      PH_EXTLEN  = 5'b00100,
      PH_KEY     = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       frame_final;
      logic [2:0] reserved_bits;
      logic       was_masked;
      logic       last_of_frame;
      logic       empty_frame;
   } result_type;

endpackage

>>> rtl/wsd_parse.sv
// Frame header parser and payload unmasking for the WebSocket frame deframer.
module wsd_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         rx_byte,
   output logic               res_valid,
   output wsd_pkg::result_type res
);
   import wsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        final_ff, final_in;
   logic [2:0]  rsv_ff, rsv_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [63:0] rem_ff, rem_in;
   logic [2:0]  ext_ff, ext_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  idx_ff, idx_in;

   logic [63:0] rem_dec;
   logic [7:0]  key_byte;
   logic        len_done;
   logic        is_last;
   logic        is_empty;
   logic [7:0]  data;

   assign rem_dec = (rem_ff == 64'd0) ? 64'd0 : rem_ff - 64'd1;

   always_comb begin
      case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      final_in  = final_ff;
      rsv_in    = rsv_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      rem_in    = rem_ff;
      ext_in    = ext_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      len_done  = 1'b0;
      res_valid = 1'b0;
      is_last   = 1'b0;
      is_empty  = 1'b0;
      data      = 8'd0;
      if (take) begin
         case (phase_ff)
            PH_HDR1: begin
               masked_in = rx_byte[7];
               if (rx_byte[6:0] == LEN_EXT16) begin
                  rem_in   = 64'd0;
                  ext_in   = EXT16_LEFT;
                  phase_in = PH_EXTLEN;
               end else if (rx_byte[6:0] == LEN_EXT64) begin
                  rem_in   = 64'd0;
                  ext_in   = EXT64_LEFT;
                  phase_in = PH_EXTLEN;
               end else begin
                  rem_in   = {57'd0, rx_byte[6:0]};
                  len_done = 1'b1;
               end
            end
            PH_EXTLEN: begin
               rem_in = {rem_ff[55:0], rx_byte};
               if (ext_ff == 3'd0) begin
                  len_done = 1'b1;
               end else begin
                  ext_in = ext_ff - 3'd1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], rx_byte};
               if (idx_ff == KEY_LAST_IDX) begin
                  idx_in = 2'd0;
                  if (rem_ff == 64'd0) begin
                     phase_in  = PH_HDR0;
                     res_valid = 1'b1;
                     is_last   = 1'b1;
                     is_empty  = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
            PH_PAYLOAD: begin
               data      = masked_ff ? (rx_byte ^ key_byte) : rx_byte;
               idx_in    = idx_ff + 2'd1;
               rem_in    = rem_dec;
               is_last   = (rem_dec == 64'd0);
               res_valid = 1'b1;
               if (is_last) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               final_in  = rx_byte[7];
               rsv_in    = rx_byte[6:4];
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
         endcase
         // Length is complete: a masked frame still needs its key first.
         if (len_done) begin
            idx_in = 2'd0;
            if (masked_in) begin
               phase_in = PH_KEY;
            end else if (rem_in == 64'd0) begin
               phase_in  = PH_HDR0;
               res_valid = 1'b1;
               is_last   = 1'b1;
               is_empty  = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
      end
   end

   always_comb begin
      res.payload_byte  = data;
      res.frame_opcode  = opcode_in;
      res.frame_final   = final_in;
      res.reserved_bits = rsv_in;
      res.was_masked    = masked_in;
      res.last_of_frame = is_last;
      res.empty_frame   = is_empty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         final_ff  <= 1'b0;
         rsv_ff    <= 3'd0;
         opcode_ff <= 4'd0;
         masked_ff <= 1'b0;
         rem_ff    <= 64'd0;
         ext_ff    <= 3'd0;
         key_ff    <= 32'd0;
         idx_ff    <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         final_ff  <= final_in;
         rsv_ff    <= rsv_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         rem_ff    <= rem_in;
         ext_ff    <= ext_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
      end
   end

   a_res_needs_take: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> take)
      else $error("parser produced an item without an accepted byte");

   a_last_payload_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (take && phase_ff == PH_PAYLOAD && rem_ff == 64'd1) |=> phase_ff == PH_HDR0)
      else $error("frame did not end after its last payload byte");

   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.empty_frame) |-> (res.last_of_frame && res.payload_byte == 8'd0))
      else $error("empty-frame marker is malformed");

endmodule

>>> rtl/wsd_skid.sv
// Output register with a skid stage for the deframer's result channel.
module wsd_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  wsd_pkg::result_type in_res,
   output logic                in_stall,
   output logic                out_valid,
   input  logic                out_stall,
   output wsd_pkg::result_type out_res
);
   import wsd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_res_ff, out_res_in;
   result_type skid_res_ff, skid_res_in;
   logic       out_free;

   assign out_free  = !out_valid_ff || !out_stall;
   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_res_in    = out_res_ff;
      skid_res_in   = skid_res_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_res_in    = skid_res_ff;
            skid_valid_in = in_valid;
            skid_res_in   = in_res;
         end else begin
            out_valid_in = in_valid;
            out_res_in   = in_res;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_res_in   = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds an item while the output register is empty");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_stall && skid_valid_ff) |=> out_res_ff == $past(skid_res_ff))
      else $error("skid item was not moved to the output register");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_valid_ff && out_stall) |-> !in_valid)
      else $error("new item arrived while both stages were full");

endmodule

>>> rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer.
// The req channel carries the received stream, one byte per item on req_rx_byte.
// The block walks each frame's header (fin, rsv, opcode, mask flag, 7-bit,
// 16-bit or 64-bit length, optional 4-byte key) and emits one rsp item per
// payload byte, unmasked, with the frame's header fields and a last marker.
// A frame with no payload emits a single item with rsp_empty_frame set.
// Header, length and key bytes produce no item otherwise.
// An item caused by an accepted byte is registered in the output register, or
// in the skid register when the output is stalled. Throughput: one byte per clock
// while req_stall is low; the parser's combinational next-state logic parses each
// byte; its longest path is the 64-bit remaining-length decrement and zero test.
// The result side has an output register plus one skid register, so a
// stalled receiver costs nothing until both are full; req_stall then rises
// (it is the skid register's valid bit) and clears once rsp_stall drops.
// Reset is synchronous and active high; it returns the parser to the first
// header byte and empties both result registers.
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_frame_final,
   output logic [2:0] rsp_reserved_bits,
   output logic       rsp_was_masked,
   output logic       rsp_last_of_frame,
   output logic       rsp_empty_frame
);
   import wsd_pkg::*;

   logic       take;
   logic       res_valid;
   result_type res;
   result_type out_res;

   assign take = req_valid && !req_stall;

   wsd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   wsd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (out_res)
   );

   assign rsp_payload_byte  = out_res.payload_byte;
   assign rsp_frame_opcode  = out_res.frame_opcode;
   assign rsp_frame_final   = out_res.frame_final;
   assign rsp_reserved_bits = out_res.reserved_bits;
   assign rsp_was_masked    = out_res.was_masked;
   assign rsp_last_of_frame = out_res.last_of_frame;
   assign rsp_empty_frame   = out_res.empty_frame;

endmodule

>>> tb/sv/tb_websocket_frame_deframer.sv
// Self-checking testbench for the WebSocket frame deframer: frame stimulus and a scoreboard.
module tb_websocket_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import wsd_pkg::*;

   localparam int IDLE_PCT       = 18;
   localparam int RANDOM_BYTES   = 1370;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLDOFF_CYCLES = 64;
   localparam int CALM_FROM      = 500;
   localparam int CALM_TO        = 800;

   typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_type;

   // Tracks the frame parse in parallel with the block and holds the payload items still owed.
   class deframe_tracker;
      phase_type   phase;
      logic        hdr_fin;
      logic [2:0]  hdr_rsv;
      logic [3:0]  hdr_op;
      logic        hdr_mask;
      logic [63:0] remain;
      logic [2:0]  ext_left;
      logic [31:0] key;
      logic [1:0]  key_idx;
      result_type  pending_payload[$];
      int          errors;

      function new();
         phase    = PH_HDR0;
         hdr_fin  = 1'b0;
         hdr_rsv  = '0;
         hdr_op   = '0;
         hdr_mask = 1'b0;
         remain   = '0;
         ext_left = '0;
         key      = '0;
         key_idx  = '0;
         errors   = 0;
      endfunction

      function void push_result(logic [7:0] data, logic last, logic empty);
         result_type r;
         r.payload_byte  = data;
         r.frame_opcode  = hdr_op;
         r.frame_final   = hdr_fin;
         r.reserved_bits = hdr_rsv;
         r.was_masked    = hdr_mask;
         r.last_of_frame = last;
         r.empty_frame   = empty;
         pending_payload = {pending_payload, r};
      endfunction

      // The length is complete: a key follows, or the payload, or the frame is already over.
      function void length_known();
         key_idx = '0;
         if (hdr_mask) begin
            phase = PH_KEY;
         end else if (remain == 0) begin
            phase = PH_HDR0;
            push_result(8'h00, 1'b1, 1'b1);
         end else begin
            phase = PH_PAYLOAD;
         end
      endfunction

      function void take_rx_byte(logic [7:0] b);
         logic [7:0] kb;
         logic       last;
         case (phase)
            PH_HDR1: begin
               hdr_mask = b[7];
               remain   = '0;
               if (b[6:0] == LEN_EXT16) begin
                  ext_left = EXT16_LEFT;
                  phase    = PH_EXTLEN;
               end else if (b[6:0] == LEN_EXT64) begin
                  ext_left = EXT64_LEFT;
                  phase    = PH_EXTLEN;
               end else begin
                  remain = {57'd0, b[6:0]};
                  length_known();
               end
            end
            PH_EXTLEN: begin
               remain = {remain[55:0], b};
               if (ext_left == 0)
                  length_known();
               else
                  ext_left = ext_left - 3'd1;
            end
            PH_KEY: begin
               key = {key[23:0], b};
               if (key_idx == KEY_LAST_IDX) begin
                  key_idx = '0;
                  if (remain == 0) begin
                     phase = PH_HDR0;
                     push_result(8'h00, 1'b1, 1'b1);
                  end else begin
                     phase = PH_PAYLOAD;
                  end
               end else begin
                  key_idx = key_idx + 2'd1;
               end
            end
            PH_PAYLOAD: begin
               kb = hdr_mask ? key[8 * (3 - int'(key_idx)) +: 8] : 8'h00;
               key_idx = key_idx + 2'd1;
               if (remain != 0)
                  remain = remain - 64'd1;
               last = (remain == 0);
               if (last)
                  phase = PH_HDR0;
               push_result(b ^ kb, last, 1'b0);
            end
            default: begin
               hdr_fin = b[7];
               hdr_rsv = b[6:4];
               hdr_op  = b[3:0];
               phase   = PH_HDR1;
            end
         endcase
      endfunction

      function void report_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         end
      endfunction

      function void check_payload(result_type got);
         result_type want;
         if (pending_payload.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual 0x%0h", $time, got);
            return;
         end
         want = pending_payload.pop_front();
         report_field("payload_byte", want.payload_byte, got.payload_byte);
         report_field("frame_opcode", want.frame_opcode, got.frame_opcode);
         report_field("frame_final", want.frame_final, got.frame_final);
         report_field("reserved_bits", want.reserved_bits, got.reserved_bits);
         report_field("was_masked", want.was_masked, got.was_masked);
         report_field("last_of_frame", want.last_of_frame, got.last_of_frame);
         report_field("empty_frame", want.empty_frame, got.empty_frame);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_frame_final;
   logic [2:0] rsp_reserved_bits;
   logic       rsp_was_masked;
   logic       rsp_last_of_frame;
   logic       rsp_empty_frame;

   deframe_tracker tracker = new();
   logic [7:0]     stream_bytes[$];
   result_type     seen_result;
   logic           req_took = 1'b0;
   logic           rsp_took = 1'b0;
   int             bytes_in = 0;
   int             results_seen = 0;
   int             stuck_cycles = 0;

   websocket_frame_deframer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_opcode  (rsp_frame_opcode),
      .rsp_frame_final   (rsp_frame_final),
      .rsp_reserved_bits (rsp_reserved_bits),
      .rsp_was_masked    (rsp_was_masked),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_empty_frame   (rsp_empty_frame)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic calm_window();
      return bytes_in >= CALM_FROM && bytes_in < CALM_TO;
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      stream_bytes = {stream_bytes, b};
   endfunction

   task automatic add_frame(input logic [7:0] head, input logic masked, input len_form_type form,
                            input logic [63:0] length, input logic [31:0] mask_val,
                            input int body_count);
      append_byte(head);
      case (form)
         FORM_EXT16: begin
            append_byte({masked, LEN_EXT16});
            append_byte(length[15:8]);
            append_byte(length[7:0]);
         end
         FORM_EXT64: begin
            append_byte({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
               append_byte(length[8 * i +: 8]);
         end
         default: begin
            append_byte({masked, length[6:0]});
         end
      endcase
      if (masked) begin
         for (int i = 3; i >= 0; i--)
            append_byte(mask_val[8 * i +: 8]);
      end
      repeat (body_count) append_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic build_stream();
      int           roll;
      int           big_left;
      logic [63:0]  len;
      len_form_type form;
      big_left = 1;
      // Empty frames closed by the length byte and by the last key byte, a short 16-bit
      // length, and a masked payload that wraps around the key.
      add_frame(8'h81, 1'b0, FORM_SHORT, 64'd0, 32'h0, 0);
      add_frame(8'hFF, 1'b1, FORM_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
      add_frame(8'h00, 1'b0, FORM_EXT16, 64'd2, 32'h0, 2);
      add_frame(8'h7A, 1'b1, FORM_SHORT, 64'd5, 32'h00FF_A55A, 5);
      while (stream_bytes.size() < RANDOM_BYTES) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)
            len = 64'd0;
         else if (roll < 88)
            len = 64'($urandom_range(1, 12));
         else
            len = 64'($urandom_range(13, 125));
         roll = $urandom_range(0, 99);
         if (roll < 70)
            form = FORM_SHORT;
         else if (roll < 88)
            form = FORM_EXT16;
         else
            form = FORM_EXT64;
         if (form == FORM_EXT16 && big_left > 0 && $urandom_range(0, 99) < 10) begin
            len = 64'(256 + $urandom_range(0, 40));
            big_left--;
         end
         add_frame(8'($urandom), 1'($urandom), form, len, $urandom, int'(len));
      end
      // An all-ones 64-bit length keeps the block in the payload until the stream runs out.
      add_frame(8'($urandom), 1'($urandom), FORM_EXT64, '1, $urandom, 30);
   endtask

   task automatic send_stream();
      int idx;
      idx = 0;
      while (idx < stream_bytes.size()) begin
         @(negedge clock);
         if (req_valid && req_took)
            idx++;
         if (idx >= stream_bytes.size()) begin
            req_valid = 1'b0;
         end else if (!req_valid || req_took) begin
            if (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
               req_valid = 1'b0;
            end else begin
               req_valid   = 1'b1;
               req_rx_byte = stream_bytes[idx];
            end
         end
      end
   endtask

   // Receiver: random stalls, plus two long hold-offs that back the block up into req_stall.
   initial begin
      int holdoff_at[2];
      int holdoffs_done;
      int hold_left;
      holdoff_at    = '{150, 600};
      holdoffs_done = 0;
      hold_left     = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holdoffs_done < 2 && results_seen >= holdoff_at[holdoffs_done]) begin
            hold_left = HOLDOFF_CYCLES;
            holdoffs_done++;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = !calm_window() && $urandom_range(0, 99) < IDLE_PCT;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         req_took = req_valid && !req_stall;
         rsp_took = rsp_valid && !rsp_stall;
         if (req_took) begin
            tracker.take_rx_byte(req_rx_byte);
            bytes_in++;
         end
         if (rsp_took) begin
            seen_result.payload_byte  = rsp_payload_byte;
            seen_result.frame_opcode  = rsp_frame_opcode;
            seen_result.frame_final   = rsp_frame_final;
            seen_result.reserved_bits = rsp_reserved_bits;
            seen_result.was_masked    = rsp_was_masked;
            seen_result.last_of_frame = rsp_last_of_frame;
            seen_result.empty_frame   = rsp_empty_frame;
            tracker.check_payload(seen_result);
            results_seen++;
         end
         if (req_took || rsp_took)
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      build_stream();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_stream();
      while (tracker.pending_payload.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_payload.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> websocket_frame_deframer.f
rtl/wsd_pkg.sv
rtl/wsd_parse.sv
rtl/wsd_skid.sv
rtl/websocket_frame_deframer.sv
tb/sv/tb_websocket_frame_deframer.sv
